[sv/positional_ordered_list_assert.svh]
// Assertion macros for the positional ordered list RTL.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define POL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional_ordered_list: implication check failed");

// Next-cycle implication, checked out of reset.
`define POL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional_ordered_list: next-cycle check failed");

`endif

[sv/pol_pkg.sv]
// Package: sizes, request codes and shared types of the positional ordered list.
`timescale 1ns / 1ps
package pol_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int VAL_W       = 32;
    localparam int POS_W       = 8;
    localparam int KIND_W      = 2;
    localparam int COUNT_OUT_W = 7;
    // compare width that holds any position and any count
    localparam int CMP_W       = 10;

    // cells are searched in groups of eight
    localparam int GRP_SIZE = 8;
    localparam int GRP_W    = 3;
    localparam int NGRP     = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GI_W     = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    // shift command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] at;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

    // registered result of one search group
    typedef struct packed {
        logic             hit;
        logic [GRP_W-1:0] idx;
        logic [VAL_W-1:0] rval;
    } t_grp_res;

endpackage

[sv/positional_ordered_list.sv]
// Top level: ordered list of signed words kept in a chain of shifting cells.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request item:
//   i_kind (insert, delete, find, read), i_value and i_position.
//   Output channel (o_out_valid / i_out_stall) returns one result item per
//   request: o_result_value, o_found, o_rejected, o_entry_count.
//   Insert and delete shift the whole cell row in the cycle of acceptance.
//   Find and read go through a registered search over groups of eight
//   cells, then a group select into the output register.
// Flow: no new request is accepted while one is in stage 1; the next
//   request is accepted at the edge at which the previous result is taken.
// Reset: synchronous, active low; the list becomes empty, no result pends.
//   Cell contents are not cleared; only positions below the count are read.
// Receiver stall: the result holds in the output register and no new
//   request is accepted until it is taken.
`timescale 1ns / 1ps
`include "positional_ordered_list_assert.svh"
module positional_ordered_list (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pol_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [pol_pkg::VAL_W-1:0]   i_value,
    input  logic [pol_pkg::POS_W-1:0]          i_position,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [pol_pkg::VAL_W-1:0]   o_result_value,
    output logic                               o_found,
    output logic                               o_rejected,
    output logic [pol_pkg::COUNT_OUT_W-1:0]    o_entry_count
);

    localparam int NCELL = pol_pkg::NGRP * pol_pkg::GRP_SIZE;

    // control state
    logic [pol_pkg::CNT_W-1:0] r_count;
    logic [pol_pkg::CNT_W-1:0] n_count;
    logic                      r_s1_vld;
    logic                      r_out_vld;

    // stage 1 payload
    logic [pol_pkg::KIND_W-1:0] r_s1_kind;
    logic [pol_pkg::POS_W-1:0]  r_s1_pos;
    logic                       r_s1_rd_ok;
    logic                       r_s1_rej;

    // output payload
    logic [pol_pkg::VAL_W-1:0]       r_out_value;
    logic                            r_out_found;
    logic                            r_out_rej;
    logic [pol_pkg::COUNT_OUT_W-1:0] r_out_count;
    logic [pol_pkg::VAL_W-1:0]       n_out_value;
    logic                            n_out_found;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic                      w_full;
    logic                      w_empty;
    logic [pol_pkg::CMP_W-1:0] w_pos_ext;
    logic [pol_pkg::CMP_W-1:0] w_cnt_ext;
    logic [pol_pkg::IDX_W-1:0] w_ins_at;
    logic [pol_pkg::IDX_W-1:0] w_del_at;
    pol_pkg::t_cell_ctl        w_ctl;

    logic [pol_pkg::VAL_W-1:0] w_vals [pol_pkg::MAX_ENTRIES];
    logic [pol_pkg::NGRP-1:0][pol_pkg::GRP_SIZE-1:0][pol_pkg::VAL_W-1:0] w_pad;
    pol_pkg::t_grp_res         w_grp [pol_pkg::NGRP];

    // handshakes
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_vld && !i_out_stall;
    assign o_in_stall = r_s1_vld || (r_out_vld && i_out_stall);

    // shift position and count update
    assign w_full    = (r_count == pol_pkg::CNT_W'(pol_pkg::MAX_ENTRIES));
    assign w_empty   = (r_count == '0);
    assign w_pos_ext = pol_pkg::CMP_W'(i_position);
    assign w_cnt_ext = pol_pkg::CMP_W'(r_count);
    assign w_ins_at  = (w_pos_ext < w_cnt_ext) ? pol_pkg::IDX_W'(i_position)
                                               : pol_pkg::IDX_W'(r_count);
    assign w_del_at  = (w_pos_ext < (w_cnt_ext - pol_pkg::CMP_W'(1)))
                       ? pol_pkg::IDX_W'(i_position)
                       : pol_pkg::IDX_W'(r_count - pol_pkg::CNT_W'(1));

    always_comb begin
        w_ctl       = '0;
        w_ctl.value = i_value;
        n_count     = r_count;
        if (w_in_acc) begin
            case (i_kind)
                pol_pkg::KIND_INSERT: begin
                    w_ctl.at = w_ins_at;
                    if (!w_full) begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + pol_pkg::CNT_W'(1);
                    end
                end
                pol_pkg::KIND_DELETE: begin
                    w_ctl.at = w_del_at;
                    if (!w_empty) begin
                        w_ctl.del = 1'b1;
                        n_count   = r_count - pol_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    w_ctl.at = '0;
                end
            endcase
        end
    end

    // cell chain
    for (genvar i = 0; i < pol_pkg::MAX_ENTRIES; i++) begin : g_cell
        logic [pol_pkg::VAL_W-1:0] w_left;
        logic [pol_pkg::VAL_W-1:0] w_right;
        if (i == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_vals[i-1];
        end
        if (i == pol_pkg::MAX_ENTRIES - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_vals[i+1];
        end
        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_idx   (pol_pkg::IDX_W'(i)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_vals[i])
        );
    end

    // pad the row to whole groups
    for (genvar i = 0; i < NCELL; i++) begin : g_pad
        if (i < pol_pkg::MAX_ENTRIES) begin : g_real
            assign w_pad[i / pol_pkg::GRP_SIZE][i % pol_pkg::GRP_SIZE] = w_vals[i];
        end else begin : g_fill
            assign w_pad[i / pol_pkg::GRP_SIZE][i % pol_pkg::GRP_SIZE] = '0;
        end
    end

    // search groups, registered at acceptance
    for (genvar g = 0; g < pol_pkg::NGRP; g++) begin : g_grp
        pol_grp u_grp (
            .i_clk   (i_clk),
            .i_en    (w_in_acc),
            .i_vals  (w_pad[g]),
            .i_base  (pol_pkg::GI_W'(g)),
            .i_count (r_count),
            .i_value (i_value),
            .i_sel   (i_position[pol_pkg::GRP_W-1:0]),
            .o_res   (w_grp[g])
        );
    end

    // stage 2: pick group and form the result
    always_comb begin
        logic                      hit;
        logic [pol_pkg::GI_W-1:0]  gi;
        logic [pol_pkg::GI_W-1:0]  gsel;
        hit  = 1'b0;
        gi   = '0;
        gsel = pol_pkg::GI_W'(r_s1_pos >> pol_pkg::GRP_W);
        for (int g = pol_pkg::NGRP - 1; g >= 0; g--) begin
            if (w_grp[g].hit) begin
                hit = 1'b1;
                gi  = pol_pkg::GI_W'(g);
            end
        end
        n_out_value = '0;
        n_out_found = 1'b0;
        case (r_s1_kind)
            pol_pkg::KIND_FIND: begin
                if (hit) begin
                    n_out_value = pol_pkg::VAL_W'({gi, w_grp[gi].idx});
                    n_out_found = 1'b1;
                end
            end
            pol_pkg::KIND_READ: begin
                if (r_s1_rd_ok) begin
                    n_out_value = w_grp[gsel].rval;
                    n_out_found = 1'b1;
                end
            end
            default: begin
                n_out_value = '0;
                n_out_found = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_s1_vld <= w_in_acc;
            if (r_s1_vld) begin
                r_out_vld <= 1'b1;
            end else if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_kind  <= i_kind;
            r_s1_pos   <= i_position;
            r_s1_rd_ok <= (w_pos_ext < w_cnt_ext);
            r_s1_rej   <= (i_kind == pol_pkg::KIND_INSERT) && w_full;
        end
        if (r_s1_vld) begin
            r_out_value <= n_out_value;
            r_out_found <= n_out_found;
            r_out_rej   <= r_s1_rej;
            r_out_count <= pol_pkg::COUNT_OUT_W'(r_count);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_out_value;
    assign o_found        = r_out_found;
    assign o_rejected     = r_out_rej;
    assign o_entry_count  = r_out_count;

    // checks
    `POL_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= pol_pkg::CNT_W'(pol_pkg::MAX_ENTRIES))
    `POL_ASSERT_IMP(a_one_in_flight, i_clk, i_rst_n, r_s1_vld, !r_out_vld)
    `POL_ASSERT_NXT(a_s1_to_out, i_clk, i_rst_n, r_s1_vld, r_out_vld && !r_s1_vld)
    `POL_ASSERT_IMP(a_reject_full, i_clk, i_rst_n, r_out_vld && r_out_rej,
        w_full && !r_out_found)

endmodule

[sv/pol_cell.sv]
// One list cell: holds an entry and shifts toward head or tail on command.
`timescale 1ns / 1ps
module pol_cell (
    input  logic                          i_clk,
    input  pol_pkg::t_cell_ctl            i_ctl,
    input  logic [pol_pkg::IDX_W-1:0]     i_idx,
    input  logic [pol_pkg::VAL_W-1:0]     i_left,
    input  logic [pol_pkg::VAL_W-1:0]     i_right,
    output logic [pol_pkg::VAL_W-1:0]     o_value
);

    logic [pol_pkg::VAL_W-1:0] r_value;
    logic [pol_pkg::VAL_W-1:0] n_value;

    // insert pulls from the head side, delete pulls from the tail side
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_idx > i_ctl.at) begin
                n_value = i_left;
            end else if (i_idx == i_ctl.at) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.del && (i_idx >= i_ctl.at)) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[sv/pol_grp.sv]
// Search group: first match and positional read over eight cells, registered.
`timescale 1ns / 1ps
module pol_grp (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic [pol_pkg::GRP_SIZE-1:0][pol_pkg::VAL_W-1:0] i_vals,
    input  logic [pol_pkg::GI_W-1:0]                 i_base,
    input  logic [pol_pkg::CNT_W-1:0]                i_count,
    input  logic [pol_pkg::VAL_W-1:0]                i_value,
    input  logic [pol_pkg::GRP_W-1:0]                i_sel,
    output pol_pkg::t_grp_res                        o_res
);

    pol_pkg::t_grp_res r_res;
    pol_pkg::t_grp_res n_res;

    // lowest occupied cell that matches wins
    always_comb begin
        logic [pol_pkg::GI_W+pol_pkg::GRP_W-1:0] cell_idx;
        n_res = '0;
        cell_idx = '0;
        for (int j = pol_pkg::GRP_SIZE - 1; j >= 0; j--) begin
            cell_idx = {i_base, pol_pkg::GRP_W'(j)};
            if ((pol_pkg::CMP_W'(cell_idx) < pol_pkg::CMP_W'(i_count))
                && (i_vals[j] == i_value)) begin
                n_res.hit = 1'b1;
                n_res.idx = pol_pkg::GRP_W'(j);
            end
        end
        n_res.rval = i_vals[i_sel];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
